// File: src/rgbhsv_pkg.sv
// Shared types and constants for the RGB to HSV pixel converter.
package rgbhsv_pkg;

    // Degrees covered by one hue sector, and sectors in a full turn
    localparam int SECTOR_DEGREES = 60;
    localparam int SECTOR_COUNT   = 6;

    // Channel that holds the maximum, ties resolved red, then green, then blue
    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } t_sector;

    // Per-pixel control flags that travel alongside the divider data
    typedef struct packed {
        t_sector sector;    // sector of the hue
        logic    neg;       // hue numerator is negative, quotient is a ceiling
        logic    hue_zero;  // gray pixel, hue forced to zero
        logic    sat_zero;  // black pixel, saturation forced to zero
    } t_flags;

endpackage

// File: src/rgbhsv_front.sv
// Front end: max/min search, sector pick and divider operand setup in two stages.
module rgbhsv_front #(
    parameter int CB     = 8,
    parameter int L      = 12,
    parameter int SECTOR = 3840
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_adv,
    input  logic                   i_valid,
    input  logic [CB-1:0]          i_red,
    input  logic [CB-1:0]          i_green,
    input  logic [CB-1:0]          i_blue,
    output logic                   o_valid,
    output rgbhsv_pkg::t_flags     o_flags,
    output logic [CB-1:0]          o_mx,
    output logic [CB-1:0]          o_sat_rem,
    output logic [L-1:0]           o_sat_sh,
    output logic [CB-1:0]          o_hue_rem,
    output logic [L-1:0]           o_hue_sh,
    output logic [CB-1:0]          o_hue_div
);

    localparam int NW = CB + L;

    // stage A signals
    logic [CB-1:0]      n_a_mx;
    logic [CB-1:0]      n_a_mn;
    logic [CB-1:0]      n_a_pos;
    logic [CB-1:0]      n_a_neg;
    rgbhsv_pkg::t_flags n_a_flags;
    logic               r_a_valid;
    logic [CB-1:0]      r_a_mx;
    logic [CB-1:0]      r_a_d;
    logic [CB-1:0]      r_a_pos;
    logic [CB-1:0]      r_a_neg;
    rgbhsv_pkg::t_flags r_a_flags;

    // stage B signals
    logic               n_b_neg;
    logic [CB-1:0]      n_b_num;
    logic [NW-1:0]      n_b_hue_dvd;
    logic [NW-1:0]      n_b_sat_dvd;
    rgbhsv_pkg::t_flags n_b_flags;
    logic               r_b_valid;
    rgbhsv_pkg::t_flags r_b_flags;
    logic [CB-1:0]      r_b_mx;
    logic [CB-1:0]      r_b_d;
    logic [NW-1:0]      r_b_hue_dvd;
    logic [NW-1:0]      r_b_sat_dvd;

    // find the maximum channel and the pair that forms the hue numerator
    always_comb begin
        n_a_flags = '0;
        if (i_red >= i_green && i_red >= i_blue) begin
            n_a_mx           = i_red;
            n_a_pos          = i_green;
            n_a_neg          = i_blue;
            n_a_flags.sector = rgbhsv_pkg::SEC_RED;
        end else if (i_green >= i_blue) begin
            n_a_mx           = i_green;
            n_a_pos          = i_blue;
            n_a_neg          = i_red;
            n_a_flags.sector = rgbhsv_pkg::SEC_GREEN;
        end else begin
            n_a_mx           = i_blue;
            n_a_pos          = i_red;
            n_a_neg          = i_green;
            n_a_flags.sector = rgbhsv_pkg::SEC_BLUE;
        end
        if (i_red <= i_green && i_red <= i_blue) begin
            n_a_mn = i_red;
        end else if (i_green <= i_blue) begin
            n_a_mn = i_green;
        end else begin
            n_a_mn = i_blue;
        end
        n_a_flags.hue_zero = (n_a_mx == n_a_mn);
        n_a_flags.sat_zero = (n_a_mx == '0);
    end

    // hold stage A
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_adv) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a_mx    <= n_a_mx;
            r_a_d     <= n_a_mx - n_a_mn;
            r_a_pos   <= n_a_pos;
            r_a_neg   <= n_a_neg;
            r_a_flags <= n_a_flags;
        end
    end

    // form both dividends; a negative numerator takes the ceiling by adding d-1
    always_comb begin
        n_b_neg      = (r_a_pos < r_a_neg);
        n_b_num      = n_b_neg ? (r_a_neg - r_a_pos) : (r_a_pos - r_a_neg);
        n_b_hue_dvd  = NW'(n_b_num) * NW'(SECTOR);
        if (n_b_neg) begin
            n_b_hue_dvd = n_b_hue_dvd + NW'(r_a_d) - NW'(1);
        end
        n_b_sat_dvd  = (NW'(r_a_d) << CB) - NW'(r_a_d);
        n_b_flags     = r_a_flags;
        n_b_flags.neg = n_b_neg;
    end

    // hold stage B
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_adv) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_b_flags   <= n_b_flags;
            r_b_mx      <= r_a_mx;
            r_b_d       <= r_a_d;
            r_b_hue_dvd <= n_b_hue_dvd;
            r_b_sat_dvd <= n_b_sat_dvd;
        end
    end

    // split each dividend into starting remainder and bits still to shift in
    assign o_valid   = r_b_valid;
    assign o_flags   = r_b_flags;
    assign o_mx      = r_b_mx;
    assign o_sat_rem = r_b_sat_dvd[NW-1:L];
    assign o_sat_sh  = r_b_sat_dvd[L-1:0];
    assign o_hue_rem = r_b_hue_dvd[NW-1:L];
    assign o_hue_sh  = r_b_hue_dvd[L-1:0];
    assign o_hue_div = r_b_d;

endmodule

// File: src/rgbhsv_cell.sv
// Divider cell: one restoring step for the saturation and hue quotients.
module rgbhsv_cell #(
    parameter int CB = 8,
    parameter int L  = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_adv,
    input  logic                   i_valid,
    input  rgbhsv_pkg::t_flags     i_flags,
    input  logic [CB-1:0]          i_mx,
    input  logic [CB-1:0]          i_sat_rem,
    input  logic [L-1:0]           i_sat_sh,
    input  logic [CB-1:0]          i_hue_rem,
    input  logic [L-1:0]           i_hue_sh,
    input  logic [CB-1:0]          i_hue_div,
    output logic                   o_valid,
    output rgbhsv_pkg::t_flags     o_flags,
    output logic [CB-1:0]          o_mx,
    output logic [CB-1:0]          o_sat_rem,
    output logic [L-1:0]           o_sat_sh,
    output logic [CB-1:0]          o_hue_rem,
    output logic [L-1:0]           o_hue_sh,
    output logic [CB-1:0]          o_hue_div
);

    logic [CB:0]        sat_ext;
    logic [CB:0]        hue_ext;
    logic               sat_ge;
    logic               hue_ge;
    logic [CB-1:0]      n_sat_rem;
    logic [CB-1:0]      n_hue_rem;
    logic               r_valid;
    rgbhsv_pkg::t_flags r_flags;
    logic [CB-1:0]      r_mx;
    logic [CB-1:0]      r_sat_rem;
    logic [L-1:0]       r_sat_sh;
    logic [CB-1:0]      r_hue_rem;
    logic [L-1:0]       r_hue_sh;
    logic [CB-1:0]      r_hue_div;

    // shift in the next dividend bit and subtract the divisor when it fits
    always_comb begin
        sat_ext   = {i_sat_rem, i_sat_sh[L-1]};
        hue_ext   = {i_hue_rem, i_hue_sh[L-1]};
        sat_ge    = (sat_ext >= {1'b0, i_mx});
        hue_ge    = (hue_ext >= {1'b0, i_hue_div});
        n_sat_rem = sat_ge ? CB'(sat_ext - {1'b0, i_mx})      : sat_ext[CB-1:0];
        n_hue_rem = hue_ge ? CB'(hue_ext - {1'b0, i_hue_div}) : hue_ext[CB-1:0];
    end

    // advance the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    // advance the payload; quotient bits enter at the bottom of the shift words
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_flags   <= i_flags;
            r_mx      <= i_mx;
            r_sat_rem <= n_sat_rem;
            r_sat_sh  <= {i_sat_sh[L-2:0], sat_ge};
            r_hue_rem <= n_hue_rem;
            r_hue_sh  <= {i_hue_sh[L-2:0], hue_ge};
            r_hue_div <= i_hue_div;
        end
    end

    assign o_valid   = r_valid;
    assign o_flags   = r_flags;
    assign o_mx      = r_mx;
    assign o_sat_rem = r_sat_rem;
    assign o_sat_sh  = r_sat_sh;
    assign o_hue_rem = r_hue_rem;
    assign o_hue_sh  = r_hue_sh;
    assign o_hue_div = r_hue_div;

endmodule

// File: src/rgbhsv_back.sv
// Back end: sector offset, hue wrap, special-case masking and output register.
module rgbhsv_back #(
    parameter int CB     = 8,
    parameter int L      = 12,
    parameter int HQ     = 12,
    parameter int HW     = 15,
    parameter int SECTOR = 3840
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_adv,
    input  logic                   i_valid,
    input  rgbhsv_pkg::t_flags     i_flags,
    input  logic [CB-1:0]          i_mx,
    input  logic [L-1:0]           i_sat_sh,
    input  logic [L-1:0]           i_hue_sh,
    output logic                   o_valid,
    output logic [HW-1:0]          o_hue,
    output logic [CB-1:0]          o_saturation,
    output logic [CB-1:0]          o_brightness
);

    localparam logic [HW-1:0] FULL_TURN_W = HW'(rgbhsv_pkg::SECTOR_COUNT * SECTOR);
    localparam logic [HW-1:0] BASE_GREEN  = HW'(2 * SECTOR);
    localparam logic [HW-1:0] BASE_BLUE   = HW'(4 * SECTOR);

    logic [HW-1:0] base;
    logic [HW-1:0] q_hue;
    logic [HW:0]   diff;
    logic [HW-1:0] n_hue;
    logic [CB-1:0] n_sat;
    logic          r_valid;
    logic [HW-1:0] r_hue;
    logic [CB-1:0] r_sat;
    logic [CB-1:0] r_mx;

    // pick the sector offset
    always_comb begin
        case (i_flags.sector)
            rgbhsv_pkg::SEC_GREEN: base = BASE_GREEN;
            rgbhsv_pkg::SEC_BLUE:  base = BASE_BLUE;
            default:               base = '0;
        endcase
    end

    // add or subtract the quotient, wrap a negative result by one turn
    always_comb begin
        q_hue = HW'(i_hue_sh[HQ-1:0]);
        diff  = {1'b0, base} - {1'b0, q_hue};
        if (i_flags.hue_zero) begin
            n_hue = '0;
        end else if (!i_flags.neg) begin
            n_hue = base + q_hue;
        end else if (diff[HW]) begin
            n_hue = diff[HW-1:0] + FULL_TURN_W;
        end else begin
            n_hue = diff[HW-1:0];
        end
        n_sat = i_flags.sat_zero ? '0 : i_sat_sh[CB-1:0];
    end

    // hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_hue <= n_hue;
            r_sat <= n_sat;
            r_mx  <= i_mx;
        end
    end

    assign o_valid      = r_valid;
    assign o_hue        = r_hue;
    assign o_saturation = r_sat;
    assign o_brightness = r_mx;

endmodule

// File: src/rgb_to_hsv_pixel.sv
// Top level of the RGB to HSV pixel converter.
//
// Input channel: i_red, i_green, i_blue with i_valid; o_stall pushes back.
// A transaction is taken on a rising edge with valid high and stall low.
// Output channel: o_hue, o_saturation, o_brightness with o_valid; the
// receiver pushes back with i_stall.
// Throughput: one pixel per cycle, sustained while the receiver keeps
// i_stall low.
// Path: from accept through two front stages, the row of divider cells
// (L of them, where L is the larger of CHANNEL_BITS and the hue quotient
// width, one quotient bit per cell) and the output register to
// o_valid.
// Stall: while a result waits with i_stall high the whole pipeline holds;
// o_stall is high exactly then, and nothing is dropped.
// Reset: synchronous, active low; all stage valid flags clear, no
// transaction is in flight afterwards and none is produced.
module rgb_to_hsv_pixel #(
    parameter int CHANNEL_BITS      = 8,
    parameter int HUE_FRACTION_BITS = 6
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [CHANNEL_BITS-1:0] i_red,
    input  logic [CHANNEL_BITS-1:0] i_green,
    input  logic [CHANNEL_BITS-1:0] i_blue,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [$clog2(rgbhsv_pkg::SECTOR_COUNT * (rgbhsv_pkg::SECTOR_DEGREES
                  << HUE_FRACTION_BITS))-1:0] o_hue,
    output logic [CHANNEL_BITS-1:0] o_saturation,
    output logic [CHANNEL_BITS-1:0] o_brightness
);

    localparam int CB        = CHANNEL_BITS;
    localparam int SECTOR    = rgbhsv_pkg::SECTOR_DEGREES << HUE_FRACTION_BITS;
    localparam int FULL_TURN = rgbhsv_pkg::SECTOR_COUNT * SECTOR;
    localparam int HQ        = $clog2(SECTOR + 1);
    localparam int L         = (CB > HQ) ? CB : HQ;
    localparam int HW        = $clog2(FULL_TURN);

    logic               adv;
    logic               c_valid   [0:L];
    rgbhsv_pkg::t_flags c_flags   [0:L];
    logic [CB-1:0]      c_mx      [0:L];
    logic [CB-1:0]      c_sat_rem [0:L];
    logic [L-1:0]       c_sat_sh  [0:L];
    logic [CB-1:0]      c_hue_rem [0:L];
    logic [L-1:0]       c_hue_sh  [0:L];
    logic [CB-1:0]      c_hue_div [0:L];

    // advance everything unless a finished result is held back
    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    rgbhsv_front #(
        .CB     (CB),
        .L      (L),
        .SECTOR (SECTOR)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_valid   (i_valid),
        .i_red     (i_red),
        .i_green   (i_green),
        .i_blue    (i_blue),
        .o_valid   (c_valid[0]),
        .o_flags   (c_flags[0]),
        .o_mx      (c_mx[0]),
        .o_sat_rem (c_sat_rem[0]),
        .o_sat_sh  (c_sat_sh[0]),
        .o_hue_rem (c_hue_rem[0]),
        .o_hue_sh  (c_hue_sh[0]),
        .o_hue_div (c_hue_div[0])
    );

    // row of divider cells, one quotient bit each
    for (genvar k = 0; k < L; k++) begin : g_cell
        rgbhsv_cell #(
            .CB (CB),
            .L  (L)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_adv     (adv),
            .i_valid   (c_valid[k]),
            .i_flags   (c_flags[k]),
            .i_mx      (c_mx[k]),
            .i_sat_rem (c_sat_rem[k]),
            .i_sat_sh  (c_sat_sh[k]),
            .i_hue_rem (c_hue_rem[k]),
            .i_hue_sh  (c_hue_sh[k]),
            .i_hue_div (c_hue_div[k]),
            .o_valid   (c_valid[k+1]),
            .o_flags   (c_flags[k+1]),
            .o_mx      (c_mx[k+1]),
            .o_sat_rem (c_sat_rem[k+1]),
            .o_sat_sh  (c_sat_sh[k+1]),
            .o_hue_rem (c_hue_rem[k+1]),
            .o_hue_sh  (c_hue_sh[k+1]),
            .o_hue_div (c_hue_div[k+1])
        );
    end

    rgbhsv_back #(
        .CB     (CB),
        .L      (L),
        .HQ     (HQ),
        .HW     (HW),
        .SECTOR (SECTOR)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_valid      (c_valid[L]),
        .i_flags      (c_flags[L]),
        .i_mx         (c_mx[L]),
        .i_sat_sh     (c_sat_sh[L]),
        .i_hue_sh     (c_hue_sh[L]),
        .o_valid      (o_valid),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_brightness (o_brightness)
    );

    // hue stays inside one turn
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hue < HW'(FULL_TURN)))
        else $error("hue outside one turn");

    // black pixel has no saturation
    a_black_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_brightness == '0) |-> (o_saturation == '0))
        else $error("black pixel with nonzero saturation");

    // zero saturation on a lit pixel means gray, so hue is zero
    a_gray_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturation == '0 && o_brightness != '0) |-> (o_hue == '0))
        else $error("gray pixel with nonzero hue");

endmodule

// File: verif/rgb_to_hsv_pixel_checker.sv
// Checker for the RGB to HSV converter: watches both channels and compares results.
module rgb_to_hsv_pixel_checker #(
    parameter int CHANNEL_BITS      = 8,
    parameter int HUE_FRACTION_BITS = 6,
    parameter int HUE_BITS          = 15
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_stall,
    input  logic [CHANNEL_BITS-1:0] i_red,
    input  logic [CHANNEL_BITS-1:0] i_green,
    input  logic [CHANNEL_BITS-1:0] i_blue,
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  logic [HUE_BITS-1:0]     i_hue,
    input  logic [CHANNEL_BITS-1:0] i_saturation,
    input  logic [CHANNEL_BITS-1:0] i_brightness,
    output int                      o_mismatches,
    output int                      o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SECTOR    = longint'(rgbhsv_pkg::SECTOR_DEGREES) << HUE_FRACTION_BITS;
    localparam longint FULL_TURN = rgbhsv_pkg::SECTOR_COUNT * SECTOR;
    localparam longint FULL_CODE = (longint'(1) << CHANNEL_BITS) - 1;

    typedef struct packed {
        logic [HUE_BITS-1:0]     hue;
        logic [CHANNEL_BITS-1:0] saturation;
        logic [CHANNEL_BITS-1:0] brightness;
    } t_pixel_hsv;

    t_pixel_hsv pending_hsv_q[$];
    int         mismatch_count = 0;

    // Hexcone conversion of one pixel; the hue quotient floors toward minus infinity
    function automatic t_pixel_hsv convert_rgb_to_hsv(input logic [CHANNEL_BITS-1:0] r,
                                                      input logic [CHANNEL_BITS-1:0] g,
                                                      input logic [CHANNEL_BITS-1:0] b);
        longint              rv, gv, bv;
        longint              peak, trough, delta, num, quot, base, hue;
        rgbhsv_pkg::t_sector sector;
        t_pixel_hsv          res;
        rv = longint'(r);
        gv = longint'(g);
        bv = longint'(b);
        // Maximum channel, ties resolved red, then green, then blue
        peak   = rv;
        sector = rgbhsv_pkg::SEC_RED;
        if (gv > peak) begin
            peak   = gv;
            sector = rgbhsv_pkg::SEC_GREEN;
        end
        if (bv > peak) begin
            peak   = bv;
            sector = rgbhsv_pkg::SEC_BLUE;
        end
        trough = rv;
        if (gv < trough) trough = gv;
        if (bv < trough) trough = bv;
        delta = peak - trough;

        res.brightness = peak[CHANNEL_BITS-1:0];
        res.saturation = '0;
        if (peak != 0) begin
            res.saturation = CHANNEL_BITS'((FULL_CODE * delta) / peak);
        end

        // Gray pixels keep hue zero
        hue = 0;
        if (delta != 0) begin
            case (sector)
                rgbhsv_pkg::SEC_RED: begin
                    num  = gv - bv;
                    base = 0;
                end
                rgbhsv_pkg::SEC_GREEN: begin
                    num  = bv - rv;
                    base = 2 * SECTOR;
                end
                default: begin
                    num  = rv - gv;
                    base = 4 * SECTOR;
                end
            endcase
            if (num >= 0) quot = (SECTOR * num) / delta;
            else          quot = -((SECTOR * (-num) + delta - 1) / delta);
            // Wrap a negative red-sector hue into one turn
            hue = (base + quot + FULL_TURN) % FULL_TURN;
        end
        res.hue = hue[HUE_BITS-1:0];
        return res;
    endfunction

    // Predict on each accepted pixel, compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        t_pixel_hsv want;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) begin
                pending_hsv_q.push_back(convert_rgb_to_hsv(i_red, i_green, i_blue));
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_hsv_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: result with no pixel pending: hue %0d sat %0d val %0d",
                                 $realtime, i_hue, i_saturation, i_brightness);
                    end
                end else begin
                    want = pending_hsv_q.pop_front();
                    if (i_hue !== want.hue || i_saturation !== want.saturation ||
                        i_brightness !== want.brightness) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display({"%0t: mismatch hue exp %0d got %0d, ",
                                      "sat exp %0d got %0d, val exp %0d got %0d"},
                                     $realtime, want.hue, i_hue,
                                     want.saturation, i_saturation,
                                     want.brightness, i_brightness);
                        end
                    end
                end
            end
        end
        o_mismatches  <= mismatch_count;
        o_outstanding <= pending_hsv_q.size();
    end

endmodule

// File: verif/rgb_to_hsv_pixel_tb.sv
// Testbench top for the RGB to HSV converter: clock, reset, stimulus and verdict.
module rgb_to_hsv_pixel_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHANNEL_BITS      = 8;
    localparam int HUE_FRACTION_BITS = 6;
    localparam int HUE_BITS = $clog2(rgbhsv_pkg::SECTOR_COUNT *
                                     (rgbhsv_pkg::SECTOR_DEGREES << HUE_FRACTION_BITS));
    localparam int RANDOM_PIXELS = 1300;
    localparam int DRAIN_CYCLES  = 30;
    localparam int CORNER_COUNT  = 24;

    // Extremes, ties, every sector on both sides of its center, and bit patterns
    localparam logic [23:0] CORNER_PIXELS [CORNER_COUNT] = '{
        24'h000000, 24'hffffff, 24'h808080, 24'hff0000, 24'h00ff00, 24'h0000ff,
        24'hffff00, 24'h00ffff, 24'hff00ff, 24'hff0001, 24'hff0100, 24'h00ff01,
        24'h01ff00, 24'h0100ff, 24'h0001ff, 24'h010000, 24'h000001, 24'h010100,
        24'hfeffff, 24'hfffefe, 24'haa5500, 24'h55aa00, 24'h7f807f, 24'h00aa55
    };

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic [CHANNEL_BITS-1:0] i_red;
    logic [CHANNEL_BITS-1:0] i_green;
    logic [CHANNEL_BITS-1:0] i_blue;
    logic                    o_valid;
    logic                    i_stall;
    logic [HUE_BITS-1:0]     o_hue;
    logic [CHANNEL_BITS-1:0] o_saturation;
    logic [CHANNEL_BITS-1:0] o_brightness;
    int                      mismatches;
    int                      outstanding;
    logic                    steady = 1'b0;

    rgb_to_hsv_pixel #(
        .CHANNEL_BITS      (CHANNEL_BITS),
        .HUE_FRACTION_BITS (HUE_FRACTION_BITS)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_brightness (o_brightness)
    );

    rgb_to_hsv_pixel_checker #(
        .CHANNEL_BITS      (CHANNEL_BITS),
        .HUE_FRACTION_BITS (HUE_FRACTION_BITS),
        .HUE_BITS          (HUE_BITS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_hue        (o_hue),
        .i_saturation (o_saturation),
        .i_brightness (o_brightness),
        .o_mismatches (mismatches),
        .o_outstanding(outstanding)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Stall results at random, except during the steady stretch
    initial begin
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            i_stall <= !steady && ($urandom_range(0, 99) < 6);
        end
    end

    // Abort a hung run
    initial begin
        #1ms;
        $display("rgb_to_hsv_pixel_tb failed");
        $finish;
    end

    // Offer one pixel, with a random idle gap first, and hold it until accepted
    task automatic send_pixel(input logic [CHANNEL_BITS-1:0] r,
                              input logic [CHANNEL_BITS-1:0] g,
                              input logic [CHANNEL_BITS-1:0] b);
        while (!steady && $urandom_range(0, 99) < 6) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_red   <= r;
        i_green <= g;
        i_blue  <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    initial begin
        logic [CHANNEL_BITS-1:0] r, g, b, lvl;
        int                      kind;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_red   = '0;
        i_green = '0;
        i_blue  = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corners
        foreach (CORNER_PIXELS[k]) begin
            send_pixel(CORNER_PIXELS[k][23:16], CORNER_PIXELS[k][15:8], CORNER_PIXELS[k][7:0]);
        end

        // Random pixels, with ties, near-grays and dark values mixed in
        for (int n = 0; n < RANDOM_PIXELS; n++) begin
            steady = (n >= 500 && n < 800);
            r    = CHANNEL_BITS'($urandom_range(0, 255));
            g    = CHANNEL_BITS'($urandom_range(0, 255));
            b    = CHANNEL_BITS'($urandom_range(0, 255));
            kind = int'($urandom_range(0, 9));
            case (kind)
                5: begin
                    // tie two channels, at 255 one time in four, else at the red level
                    lvl = ($urandom_range(0, 3) == 0) ? 8'd255 : r;
                    case ($urandom_range(0, 2))
                        0: begin r = lvl; g = lvl; end
                        1: begin g = lvl; b = lvl; end
                        default: begin r = lvl; b = lvl; end
                    endcase
                end
                6: begin
                    // near-gray: small spread around one level
                    lvl = CHANNEL_BITS'($urandom_range(2, 253));
                    r = CHANNEL_BITS'(lvl + $urandom_range(0, 2) - 1);
                    g = CHANNEL_BITS'(lvl + $urandom_range(0, 2) - 1);
                    b = CHANNEL_BITS'(lvl + $urandom_range(0, 2) - 1);
                end
                7: begin
                    r = CHANNEL_BITS'($urandom_range(0, 3));
                    g = CHANNEL_BITS'($urandom_range(0, 3));
                    b = CHANNEL_BITS'($urandom_range(0, 3));
                end
                8: begin
                    // pin channels to the rails
                    if ($urandom_range(0, 1) == 1) r = 8'd255; else g = 8'd0;
                    if ($urandom_range(0, 1) == 1) b = 8'd0;
                end
                default: ;
            endcase
            send_pixel(r, g, b);
        end
        steady = 1'b0;
        i_valid <= 1'b0;

        // Drain every pending result, then watch for stray ones
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("rgb_to_hsv_pixel_tb passed");
        end else begin
            $display("rgb_to_hsv_pixel_tb failed");
        end
        $finish;
    end

endmodule
